[rtl/ssct_pkg.sv]
// shared widths, constants and types of the swept sphere contact time core
package ssct_pkg;

	// coordinate and field formats
	localparam int COORD_BITS  = 21;
	localparam int POS_BITS    = 63;
	localparam int RADIUS_BITS = 20;
	localparam int MOTION_BITS = 21;
	localparam int TIME_FRAC   = 16;
	localparam int TIME_BITS   = 32;

	localparam logic [MOTION_BITS-1:0] MOTION_RESET = MOTION_BITS'(10);
	localparam logic [TIME_BITS-1:0]   TIME_MAX     = {1'b0, {(TIME_BITS-1){1'b1}}};
	localparam logic [TIME_BITS-1:0]   TIME_MIN     = {1'b1, {(TIME_BITS-1){1'b0}}};

	// offset, motion and their products
	localparam int D_W    = COORD_BITS + 1;
	localparam int V_W    = COORD_BITS + 2;
	localparam int DD_W   = 2 * COORD_BITS + 1;
	localparam int VV_W   = 2 * COORD_BITS + 3;
	localparam int DV_W   = 2 * COORD_BITS + 2;
	localparam int DSQ_W  = 2 * COORD_BITS + 2;
	localparam int A_W    = 2 * COORD_BITS + 4;
	localparam int DOT_W  = 2 * COORD_BITS + 4;
	localparam int ADOT_W = DOT_W - 1;
	localparam int RSUM_W = RADIUS_BITS + 1;
	localparam int RSQ_W  = 2 * RSUM_W;
	localparam int CMP_W  = (DSQ_W > RSQ_W) ? DSQ_W : RSQ_W;
	localparam int SPLIT  = COORD_BITS + 2;

	// discriminant and square root
	localparam int DISC_W   = A_W + DSQ_W;
	localparam int SQ_SHIFT = 2 * TIME_FRAC;
	localparam int ROOT_W   = (DISC_W + SQ_SHIFT) / 2;
	localparam int SQ_W     = 2 * ROOT_W;
	localparam int REM_W    = ROOT_W + 3;

	// numerator and quotient
	localparam int C_W   = ADOT_W + TIME_FRAC;
	localparam int NUM_W = C_W + 1;
	localparam int Q_W   = TIME_BITS;
	localparam int DR_W  = A_W + 1;

	// per item control carried along the pipeline
	typedef struct packed {
		logic              done;   // result settled early, time is zero
		logic              hit;
		logic              neg;    // dot > 0, time comes out negative
		logic [ADOT_W-1:0] adot;
		logic [A_W-1:0]    a;
	} ssct_ctl_t;

endpackage

[rtl/ssct_front.sv]
// front stages: offsets, motion, dot products and discriminant
module ssct_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [ssct_pkg::RADIUS_BITS-1:0]    radius_first,
	input  logic [ssct_pkg::POS_BITS-1:0]       start_first,
	input  logic [ssct_pkg::POS_BITS-1:0]       end_first,
	input  logic [ssct_pkg::RADIUS_BITS-1:0]    radius_second,
	input  logic [ssct_pkg::POS_BITS-1:0]       start_second,
	input  logic [ssct_pkg::POS_BITS-1:0]       end_second,
	input  logic [ssct_pkg::MOTION_BITS-1:0]    min_motion,
	output logic                                out_valid,
	output logic [ssct_pkg::SQ_W-1:0]           out_val,
	output ssct_pkg::ssct_ctl_t                 out_ctl
);

	localparam int C      = ssct_pkg::COORD_BITS;
	localparam int D_W    = ssct_pkg::D_W;
	localparam int V_W    = ssct_pkg::V_W;
	localparam int DD_W   = ssct_pkg::DD_W;
	localparam int VV_W   = ssct_pkg::VV_W;
	localparam int DV_W   = ssct_pkg::DV_W;
	localparam int DSQ_W  = ssct_pkg::DSQ_W;
	localparam int A_W    = ssct_pkg::A_W;
	localparam int DOT_W  = ssct_pkg::DOT_W;
	localparam int ADOT_W = ssct_pkg::ADOT_W;
	localparam int RSUM_W = ssct_pkg::RSUM_W;
	localparam int RSQ_W  = ssct_pkg::RSQ_W;
	localparam int CMP_W  = ssct_pkg::CMP_W;
	localparam int H      = ssct_pkg::SPLIT;
	localparam int DISC_W = ssct_pkg::DISC_W;
	localparam int AH_W   = ADOT_W - H;
	localparam int BH_W   = A_W - H;
	localparam int CH_W   = DSQ_W - H;

	// stage 1
	logic signed [D_W-1:0] d_n [3];
	logic signed [V_W-1:0] v_n [3];
	logic signed [D_W-1:0] d_s1 [3];
	logic signed [V_W-1:0] v_s1 [3];
	logic [RSUM_W-1:0]     rsum_s1;
	logic                  vld_s1;

	// stage 2
	logic [DD_W-1:0]        dd_n [3];
	logic [VV_W-1:0]        vv_n [3];
	logic signed [DV_W-1:0] dv_n [3];
	logic [DD_W-1:0]        dd_s2 [3];
	logic [VV_W-1:0]        vv_s2 [3];
	logic signed [DV_W-1:0] dv_s2 [3];
	logic [RSQ_W-1:0]       rsq_s2;
	logic                   vld_s2;

	// stage 3
	logic [DSQ_W-1:0]        dsq_s3;
	logic [A_W-1:0]          a_s3;
	logic signed [DOT_W-1:0] dot_s3;
	logic [RSQ_W-1:0]        rsq_s3;
	logic                    vld_s3;

	// stage 4
	logic [DOT_W-1:0]    mag;
	ssct_pkg::ssct_ctl_t ctl_n4, ctl_s4;
	logic [DSQ_W-1:0]    dm_s4;
	logic                vld_s4;

	// stage 5
	logic [2*H-1:0]       aa_ll_s5;
	logic [H+AH_W-1:0]    aa_lh_s5;
	logic [2*AH_W-1:0]    aa_hh_s5;
	logic [2*H-1:0]       bc_ll_s5;
	logic [H+CH_W-1:0]    bc_lh_s5;
	logic [BH_W+H-1:0]    bc_hl_s5;
	logic [BH_W+CH_W-1:0] bc_hh_s5;
	ssct_pkg::ssct_ctl_t  ctl_s5;
	logic                 vld_s5;

	// stage 6
	logic [DISC_W-1:0]   dotsq_s6;
	logic [DISC_W-1:0]   prod_s6;
	ssct_pkg::ssct_ctl_t ctl_s6;
	logic                vld_s6;

	// stage 7
	logic [DISC_W:0]     diff;
	ssct_pkg::ssct_ctl_t ctl_n7, ctl_s7;
	logic [DISC_W-1:0]   disc_s7;
	logic                vld_s7;

	for (genvar i = 0; i < 3; i++) begin : g_axis
		logic signed [C-1:0]    p1, p2, q1, q2;
		logic signed [DV_W-1:0] de, dve, vde;
		logic signed [VV_W:0]   ve;
		logic signed [DV_W-1:0] dd_full;
		logic signed [VV_W:0]   vv_full;

		assign p1 = signed'(start_first[i*C +: C]);
		assign p2 = signed'(end_first[i*C +: C]);
		assign q1 = signed'(start_second[i*C +: C]);
		assign q2 = signed'(end_second[i*C +: C]);

		assign d_n[i] = D_W'(p1) - D_W'(q1);
		assign v_n[i] = (V_W'(p2) - V_W'(p1)) - (V_W'(q2) - V_W'(q1));

		assign de      = DV_W'(d_s1[i]);
		assign dve     = DV_W'(d_s1[i]);
		assign vde     = DV_W'(v_s1[i]);
		assign ve      = (VV_W+1)'(v_s1[i]);
		assign dd_full = de * de;
		assign vv_full = ve * ve;
		assign dd_n[i] = dd_full[DD_W-1:0];
		assign vv_n[i] = vv_full[VV_W-1:0];
		assign dv_n[i] = dve * vde;
	end

	// early decisions: too little motion, already overlapping
	always_comb begin
		mag = dot_s3[DOT_W-1] ? DOT_W'(-dot_s3) : DOT_W'(dot_s3);
		ctl_n4.done = (a_s3 <= A_W'(min_motion)) || (CMP_W'(dsq_s3) <= CMP_W'(rsq_s3));
		ctl_n4.hit  = !(a_s3 <= A_W'(min_motion));
		ctl_n4.neg  = !dot_s3[DOT_W-1] && (dot_s3 != '0);
		ctl_n4.adot = mag[ADOT_W-1:0];
		ctl_n4.a    = a_s3;
	end

	// miss when dot^2 < a * (dsq - rsq)
	always_comb begin
		diff   = {1'b0, dotsq_s6} - {1'b0, prod_s6};
		ctl_n7 = ctl_s6;
		if (!ctl_s6.done) begin
			ctl_n7.done = diff[DISC_W];
			ctl_n7.hit  = !diff[DISC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= d_n[i];
				v_s1[i]  <= v_n[i];
				dd_s2[i] <= dd_n[i];
				vv_s2[i] <= vv_n[i];
				dv_s2[i] <= dv_n[i];
			end
			rsum_s1 <= RSUM_W'(radius_first) + RSUM_W'(radius_second);

			rsq_s2 <= RSQ_W'(rsum_s1) * RSQ_W'(rsum_s1);

			dsq_s3 <= DSQ_W'(dd_s2[0]) + DSQ_W'(dd_s2[1]) + DSQ_W'(dd_s2[2]);
			a_s3   <= A_W'(vv_s2[0]) + A_W'(vv_s2[1]) + A_W'(vv_s2[2]);
			dot_s3 <= DOT_W'(dv_s2[0]) + DOT_W'(dv_s2[1]) + DOT_W'(dv_s2[2]);
			rsq_s3 <= rsq_s2;

			ctl_s4 <= ctl_n4;
			dm_s4  <= DSQ_W'(CMP_W'(dsq_s3) - CMP_W'(rsq_s3));

			// partial products of dot^2 and a * (dsq - rsq)
			aa_ll_s5 <= (2*H)'(ctl_s4.adot[H-1:0]) * (2*H)'(ctl_s4.adot[H-1:0]);
			aa_lh_s5 <= (H+AH_W)'(ctl_s4.adot[H-1:0]) * (H+AH_W)'(ctl_s4.adot[ADOT_W-1:H]);
			aa_hh_s5 <= (2*AH_W)'(ctl_s4.adot[ADOT_W-1:H])
				* (2*AH_W)'(ctl_s4.adot[ADOT_W-1:H]);
			bc_ll_s5 <= (2*H)'(ctl_s4.a[H-1:0]) * (2*H)'(dm_s4[H-1:0]);
			bc_lh_s5 <= (H+CH_W)'(ctl_s4.a[H-1:0]) * (H+CH_W)'(dm_s4[DSQ_W-1:H]);
			bc_hl_s5 <= (BH_W+H)'(ctl_s4.a[A_W-1:H]) * (BH_W+H)'(dm_s4[H-1:0]);
			bc_hh_s5 <= (BH_W+CH_W)'(ctl_s4.a[A_W-1:H]) * (BH_W+CH_W)'(dm_s4[DSQ_W-1:H]);
			ctl_s5   <= ctl_s4;

			dotsq_s6 <= (DISC_W'(aa_hh_s5) << (2*H)) + (DISC_W'(aa_lh_s5) << (H+1))
				+ DISC_W'(aa_ll_s5);
			prod_s6  <= (DISC_W'(bc_hh_s5) << (2*H))
				+ ((DISC_W'(bc_lh_s5) + DISC_W'(bc_hl_s5)) << H) + DISC_W'(bc_ll_s5);
			ctl_s6   <= ctl_s5;

			disc_s7 <= diff[DISC_W-1:0];
			ctl_s7  <= ctl_n7;
		end
	end

	assign out_valid = vld_s7;
	assign out_val   = {disc_s7, {ssct_pkg::SQ_SHIFT{1'b0}}};
	assign out_ctl   = ctl_s7;

endmodule

[rtl/ssct_sqrt.sv]
// pipelined integer square root, one root bit per stage
module ssct_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [ssct_pkg::SQ_W-1:0]    in_val,
	input  ssct_pkg::ssct_ctl_t          in_ctl,
	output logic                         out_valid,
	output logic [ssct_pkg::ROOT_W-1:0]  out_root,
	output logic                         out_exact,
	output ssct_pkg::ssct_ctl_t          out_ctl
);

	localparam int N     = ssct_pkg::ROOT_W;
	localparam int SQ_W  = ssct_pkg::SQ_W;
	localparam int REM_W = ssct_pkg::REM_W;

	logic [REM_W-1:0]    rem_c [N];
	logic [N-1:0]        root_c [N];
	logic [SQ_W-1:0]     val_c [N];
	ssct_pkg::ssct_ctl_t ctl_c [N];
	logic [N-1:0]        vld_c;

	logic [REM_W-1:0]    rem_n [N];
	logic [N-1:0]        root_n [N];
	logic [SQ_W-1:0]     val_n [N];

	logic [REM_W-1:0]    rem_s [N];
	logic [N-1:0]        root_s [N];
	logic [SQ_W-1:0]     val_s [N];
	ssct_pkg::ssct_ctl_t ctl_s [N];
	logic [N-1:0]        vld_s;

	always_comb begin
		logic [REM_W-1:0] rn;
		logic [REM_W-1:0] tr;
		logic             ge;

		rem_c[0]  = '0;
		root_c[0] = '0;
		val_c[0]  = in_val;
		ctl_c[0]  = in_ctl;
		vld_c[0]  = in_valid;
		for (int g = 1; g < N; g++) begin
			rem_c[g]  = rem_s[g-1];
			root_c[g] = root_s[g-1];
			val_c[g]  = val_s[g-1];
			ctl_c[g]  = ctl_s[g-1];
			vld_c[g]  = vld_s[g-1];
		end
		for (int g = 0; g < N; g++) begin
			rn        = {rem_c[g][REM_W-3:0], val_c[g][SQ_W-1 -: 2]};
			tr        = {1'b0, root_c[g], 2'b01};
			ge        = (rn >= tr);
			rem_n[g]  = ge ? (rn - tr) : rn;
			root_n[g] = {root_c[g][N-2:0], ge};
			val_n[g]  = val_c[g] << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= vld_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < N; g++) begin
				rem_s[g]  <= rem_n[g];
				root_s[g] <= root_n[g];
				val_s[g]  <= val_n[g];
				ctl_s[g]  <= ctl_c[g];
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_root  = root_s[N-1];
	assign out_exact = (rem_s[N-1] == '0);
	assign out_ctl   = ctl_s[N-1];

endmodule

[rtl/ssct_div.sv]
// numerator, pipelined restoring divide by a, saturation to q16.16
module ssct_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [ssct_pkg::ROOT_W-1:0]     in_root,
	input  logic                            in_exact,
	input  ssct_pkg::ssct_ctl_t             in_ctl,
	output logic                            out_valid,
	output logic                            hit,
	output logic signed [ssct_pkg::TIME_BITS-1:0] contact_time
);

	localparam int Q_W   = ssct_pkg::Q_W;
	localparam int NUM_W = ssct_pkg::NUM_W;
	localparam int DR_W  = ssct_pkg::DR_W;
	localparam int C_W   = ssct_pkg::C_W;

	// numerator stage
	logic [C_W-1:0]      c_val;
	logic [NUM_W-1:0]    cs;
	logic [NUM_W-1:0]    num_n;
	logic [NUM_W-1:0]    num_s0;
	ssct_pkg::ssct_ctl_t ctl_s0;
	logic                vld_s0;

	// divide stages
	logic [DR_W-1:0]     r_c [Q_W];
	logic [Q_W-1:0]      lo_c [Q_W];
	logic [Q_W-1:0]      q_c [Q_W];
	logic [Q_W-1:0]      ovf_c;
	ssct_pkg::ssct_ctl_t ctl_c [Q_W];
	logic [Q_W-1:0]      vld_c;

	logic [DR_W-1:0]     r_n [Q_W];
	logic [Q_W-1:0]      q_n [Q_W];

	logic [DR_W-1:0]     r_s [Q_W];
	logic [Q_W-1:0]      lo_s [Q_W];
	logic [Q_W-1:0]      q_s [Q_W];
	logic [Q_W-1:0]      ovf_s;
	ssct_pkg::ssct_ctl_t ctl_s [Q_W];
	logic [Q_W-1:0]      vld_s;

	// output
	logic [Q_W-1:0]                q_last;
	logic                          sat;
	logic [ssct_pkg::TIME_BITS-1:0] time_n;
	logic                          hit_q;
	logic [ssct_pkg::TIME_BITS-1:0] time_q;
	logic                          vld_q;

	// dot <= 0 rounds the root up so the quotient truncates toward zero
	always_comb begin
		c_val = {in_ctl.adot, {ssct_pkg::TIME_FRAC{1'b0}}};
		cs    = NUM_W'(in_root) + NUM_W'(!in_exact);
		if (in_ctl.neg) begin
			num_n = NUM_W'(c_val) + NUM_W'(in_root);
		end else if (NUM_W'(c_val) >= cs) begin
			num_n = NUM_W'(c_val) - cs;
		end else begin
			num_n = '0;
		end
	end

	always_comb begin
		logic [DR_W-1:0] rn;
		logic            ge;

		r_c[0]   = DR_W'(num_s0[NUM_W-1:Q_W]);
		lo_c[0]  = num_s0[Q_W-1:0];
		q_c[0]   = '0;
		ovf_c[0] = DR_W'(num_s0[NUM_W-1:Q_W]) >= DR_W'(ctl_s0.a);
		ctl_c[0] = ctl_s0;
		vld_c[0] = vld_s0;
		for (int g = 1; g < Q_W; g++) begin
			r_c[g]   = r_s[g-1];
			lo_c[g]  = lo_s[g-1];
			q_c[g]   = q_s[g-1];
			ovf_c[g] = ovf_s[g-1];
			ctl_c[g] = ctl_s[g-1];
			vld_c[g] = vld_s[g-1];
		end
		for (int g = 0; g < Q_W; g++) begin
			rn     = {r_c[g][DR_W-2:0], lo_c[g][Q_W-1]};
			ge     = (rn >= DR_W'(ctl_c[g].a));
			r_n[g] = ge ? (rn - DR_W'(ctl_c[g].a)) : rn;
			q_n[g] = {q_c[g][Q_W-2:0], ge};
		end
	end

	always_comb begin
		q_last = q_s[Q_W-1];
		if (ctl_s[Q_W-1].neg) begin
			sat    = ovf_s[Q_W-1] || (q_last[Q_W-1] && (q_last[Q_W-2:0] != '0));
			time_n = sat ? ssct_pkg::TIME_MIN : ssct_pkg::TIME_BITS'(Q_W'(0) - q_last);
		end else begin
			sat    = ovf_s[Q_W-1] || q_last[Q_W-1];
			time_n = sat ? ssct_pkg::TIME_MAX : ssct_pkg::TIME_BITS'(q_last);
		end
		if (ctl_s[Q_W-1].done) begin
			time_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
			vld_s  <= '0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
			vld_s  <= vld_c;
			vld_q  <= vld_s[Q_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s0 <= num_n;
			ctl_s0 <= in_ctl;
			for (int g = 0; g < Q_W; g++) begin
				r_s[g]   <= r_n[g];
				lo_s[g]  <= lo_c[g] << 1;
				q_s[g]   <= q_n[g];
				ctl_s[g] <= ctl_c[g];
			end
			ovf_s  <= ovf_c;
			hit_q  <= ctl_s[Q_W-1].hit;
			time_q <= time_n;
		end
	end

	assign out_valid    = vld_q;
	assign hit          = hit_q;
	assign contact_time = signed'(time_q);

endmodule

[rtl/swept_sphere_collision_time_core.sv]
// top level of the swept sphere contact time core
//
// requests carry two spheres: a radius and a start and end point for each,
// points packed as three signed q11.10 coordinates with x in the low bits.
// each request yields one result: hit, and the first contact time as a
// signed q16.16 fraction of the step (zero when there is no hit).
// in_valid/in_ready take a request, out_valid/out_ready hand back a result.
// cfg_wr_en writes min_motion_sq in the same cycle; write it only while idle.
// the pipe has 7 front stages (offsets, products, sums, early
// decisions, split products, discriminant), 61 square root stages (one root
// bit each), one numerator stage, 32 divide stages (one quotient bit each)
// and the output register. throughput is one request per cycle while the output is not stalled.
// all stages move together; when a result waits at the output and out_ready
// is low the whole pipe holds and in_ready drops, nothing is lost or repeated.
// reset clears every valid bit and loads min_motion_sq with 10.
module swept_sphere_collision_time_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ssct_pkg::RADIUS_BITS-1:0]      radius_first,
	input  logic [ssct_pkg::POS_BITS-1:0]         start_first,
	input  logic [ssct_pkg::POS_BITS-1:0]         end_first,
	input  logic [ssct_pkg::RADIUS_BITS-1:0]      radius_second,
	input  logic [ssct_pkg::POS_BITS-1:0]         start_second,
	input  logic [ssct_pkg::POS_BITS-1:0]         end_second,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  hit,
	output logic signed [ssct_pkg::TIME_BITS-1:0] contact_time,
	input  logic                                  cfg_wr_en,
	input  logic [ssct_pkg::MOTION_BITS-1:0]      cfg_wr_data
);

	logic                                min_motion_q;
	logic [ssct_pkg::MOTION_BITS-1:0]    min_motion_sq_q;
	logic                                en;

	logic                                fr_valid;
	logic [ssct_pkg::SQ_W-1:0]           fr_val;
	ssct_pkg::ssct_ctl_t                 fr_ctl;

	logic                                sq_valid;
	logic [ssct_pkg::ROOT_W-1:0]         sq_root;
	logic                                sq_exact;
	ssct_pkg::ssct_ctl_t                 sq_ctl;

	// pipe advances unless a finished result is stuck at the output
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// threshold register for the relative motion squared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_motion_sq_q <= ssct_pkg::MOTION_RESET;
			min_motion_q    <= 1'b0;
		end else begin
			min_motion_q <= cfg_wr_en;
			if (cfg_wr_en) begin
				min_motion_sq_q <= cfg_wr_data;
			end
		end
	end

	// offsets, products, early decisions and discriminant
	ssct_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (in_valid),
		.radius_first  (radius_first),
		.start_first   (start_first),
		.end_first     (end_first),
		.radius_second (radius_second),
		.start_second  (start_second),
		.end_second    (end_second),
		.min_motion    (min_motion_sq_q),
		.out_valid     (fr_valid),
		.out_val       (fr_val),
		.out_ctl       (fr_ctl)
	);

	// square root of the scaled discriminant
	ssct_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_val    (fr_val),
		.in_ctl    (fr_ctl),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_exact (sq_exact),
		.out_ctl   (sq_ctl)
	);

	// numerator, divide by a, saturate, output register
	ssct_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (sq_valid),
		.in_root      (sq_root),
		.in_exact     (sq_exact),
		.in_ctl       (sq_ctl),
		.out_valid    (out_valid),
		.hit          (hit),
		.contact_time (contact_time)
	);

	// a miss always reports zero time
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> contact_time == '0)
		else $error("miss with nonzero contact time");

	// a config write lands in the threshold register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> min_motion_q && min_motion_sq_q == $past(cfg_wr_data))
		else $error("threshold register not written");

	// requests are refused only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without an output stall");

endmodule
